[sv/gfau_pkg.sv]
// Package with the shared types, codes and field arithmetic of the GF(2^8) unit.
package gfau_pkg;

   localparam logic [7:0] GF_REDUCE = 8'h1b;
   localparam logic [7:0] GF_ONE    = 8'h01;
   localparam logic [7:0] GF_ZERO   = 8'h00;
   localparam int unsigned INV_STEPS = 7;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_INV = 2'd2
   } gfau_op_type;

   typedef struct packed {
      gfau_op_type op;
      logic [7:0]  power;
      logic [7:0]  acc;
   } gfau_data_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = GF_ZERO;
      for (int i = 7; i >= 0; i--) begin
         acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_REDUCE : GF_ZERO);
         if (a[i]) begin
            acc = acc ^ b;
         end
      end
      return acc;
   endfunction

   // Squaring is linear over GF(2): spread the bits, then fold the high part back.
   function automatic logic [7:0] gf_sqr(input logic [7:0] a);
      logic [14:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[2*i] = a[i];
      end
      for (int i = 14; i >= 8; i--) begin
         if (w[i]) begin
            w[i -: 9] = w[i -: 9] ^ {1'b1, GF_REDUCE};
         end
      end
      return w[7:0];
   endfunction

endpackage

[sv/gfau_entry.sv]
// Entry stage: decodes the request, forms sum or product, and seeds the inverse.
module gfau_entry import gfau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_type,
   input  logic [7:0]    req_operand_a,
   input  logic [7:0]    req_operand_b,
   input  logic          out_ready,
   output logic          out_valid,
   output gfau_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   gfau_data_type data_ff;
   gfau_data_type data_in;
   logic          load;

   assign req_ready = !valid_ff || out_ready;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !out_ready);

   always_comb begin
      data_in.op    = gfau_op_type'(req_type);
      data_in.power = req_operand_a;
      unique case (req_type)
         OP_ADD:  data_in.acc = req_operand_a ^ req_operand_b;
         OP_MUL:  data_in.acc = gf_mul(req_operand_a, req_operand_b);
         OP_INV:  data_in.acc = GF_ONE;
         default: data_in.acc = GF_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/gfau_inv_stage.sv]
// One exponentiation step of the inverse: square the power, multiply it into the product.
module gfau_inv_stage import gfau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  gfau_data_type in_data,
   input  logic          out_ready,
   output logic          out_valid,
   output gfau_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   gfau_data_type data_ff;
   gfau_data_type data_in;
   logic          load;
   logic [7:0]    sq;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_comb begin
      sq      = gf_sqr(in_data.power);
      data_in = in_data;
      if (in_data.op == OP_INV) begin
         data_in.power = sq;
         data_in.acc   = gf_mul(sq, in_data.acc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/gf256_arith_unit_top.sv]
// Top level of the pipelined GF(2^8) arithmetic unit.
// The unit adds, multiplies or inverts bytes in GF(2^8) reduced by x^8+x^4+x^3+x+1; the
// inverse of zero is zero and operation code 3 returns zero. It accepts one request per
// cycle while the output side is ready, and each result passes through the entry stage
// and then the seven squaring and multiplying steps of the inverse, one register stage
// each. Stalls back up stage by stage.
module gf256_arith_unit_top import gfau_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result
);

   gfau_data_type stage_data  [0:INV_STEPS];
   logic          stage_valid [0:INV_STEPS];
   logic          stage_ready [1:INV_STEPS+1];

   gfau_entry u_entry (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .out_ready     (stage_ready[1]),
      .out_valid     (stage_valid[0]),
      .out_data      (stage_data[0])
   );

   for (genvar i = 1; i <= INV_STEPS; i++) begin : g_step
      gfau_inv_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i-1]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i-1]),
         .out_ready (stage_ready[i+1]),
         .out_valid (stage_valid[i]),
         .out_data  (stage_data[i])
      );
   end

   assign stage_ready[INV_STEPS+1] = rsp_ready;
   assign rsp_valid  = stage_valid[INV_STEPS];
   assign rsp_result = stage_data[INV_STEPS].acc;

endmodule

[sv/gfau_checker.sv]
// Port checker for the GF(2^8) unit, bound to its top level.
module gfau_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic [7:0] req_operand_a,
   input logic [7:0] req_operand_b,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_free_output_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("Request refused while the output side could move.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("Stalled result changed or vanished.");

   a_request_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable({req_type, req_operand_a, req_operand_b}))
      else $error("Waiting request changed or vanished.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_fire, 8) && $past(rsp_ready, 1) && $past(rsp_ready, 2) &&
       $past(rsp_ready, 3) && $past(rsp_ready, 4) && $past(rsp_ready, 5) &&
       $past(rsp_ready, 6) && $past(rsp_ready, 7) && !$past(reset, 8) &&
       !$past(reset, 4) && !$past(reset, 1)) |-> rsp_valid)
      else $error("Result missing eight cycles after its request.");

endmodule

bind gf256_arith_unit_top gfau_checker u_gfau_checker (.*);

[tb/tb_gf256_arith_unit_top.sv]
// Testbench for gf256_arith_unit_top: directed and random field operations checked in order.
`timescale 1ns / 100ps

module tb_gf256_arith_unit_top;
   import gfau_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PERCENT = 17;
   localparam int HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = OP_ADD;
   logic [7:0] req_operand_a = 8'h00;
   logic [7:0] req_operand_b = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_result;

   logic [7:0] expected_results[$];
   logic [7:0] next_expected;
   int         error_count = 0;
   int         quiet_cycles = 0;
   int         hold_left = 0;
   bit         hold_pending = 1'b0;
   bit         steady_flow = 1'b0;

   gf256_arith_unit_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] field_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : GF_ZERO);
   endfunction

   function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] term;
      acc = GF_ZERO;
      term = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) begin
            acc = acc ^ term;
         end
         term = field_double(term);
      end
      return acc;
   endfunction

   // The inverse is x^254, which also sends zero to zero.
   function automatic logic [7:0] field_inverse(input logic [7:0] x);
      logic [7:0]  acc;
      logic [7:0]  base;
      int unsigned exponent;
      acc = GF_ONE;
      base = x;
      exponent = 254;
      while (exponent != 0) begin
         if ((exponent & 1) != 0) begin
            acc = field_product(acc, base);
         end
         base = field_product(base, base);
         exponent = exponent >> 1;
      end
      return acc;
   endfunction

   function automatic logic [7:0] field_result(input logic [1:0] op, input logic [7:0] a,
                                               input logic [7:0] b);
      case (op)
         OP_ADD: return a ^ b;
         OP_MUL: return field_product(a, b);
         OP_INV: return field_inverse(a);
         default: return GF_ZERO;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s, result 0x%02h, expected 0x%02h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_request(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
      while (!steady_flow && $urandom_range(99, 0) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_results.push_back(field_result(op, a, b));
   endtask

   task automatic send_random_request();
      logic [1:0] op;
      if ($urandom_range(9, 0) == 0) begin
         op = OP_UNUSED;
      end else begin
         case ($urandom_range(2, 0))
            0: op = OP_ADD;
            1: op = OP_MUL;
            default: op = OP_INV;
         endcase
      end
      send_request(op, 8'($urandom), 8'($urandom));
   endtask

   task automatic test_addition_corners();
      send_request(OP_ADD, 8'h00, 8'h00);
      send_request(OP_ADD, 8'hff, 8'hff);
      send_request(OP_ADD, 8'hff, 8'h00);
      send_request(OP_ADD, 8'ha5, 8'h5a);
      send_request(OP_ADD, 8'h80, 8'h01);
   endtask

   task automatic test_multiply_corners();
      send_request(OP_MUL, 8'h00, 8'hff);
      send_request(OP_MUL, 8'hff, 8'h00);
      send_request(OP_MUL, 8'h01, 8'hb7);
      send_request(OP_MUL, 8'hff, 8'hff);
      send_request(OP_MUL, 8'h80, 8'h80);
      send_request(OP_MUL, 8'h57, 8'h83);
      send_request(OP_MUL, 8'h02, 8'h80);
   endtask

   task automatic test_inverse_corners();
      send_request(OP_INV, 8'h00, 8'h00);
      send_request(OP_INV, 8'h01, 8'hff);
      send_request(OP_INV, 8'hff, 8'h00);
      send_request(OP_INV, 8'h80, 8'h5a);
      send_request(OP_INV, 8'h53, 8'hca);
      send_request(OP_INV, 8'h02, 8'h33);
   endtask

   task automatic test_unused_code();
      send_request(OP_UNUSED, 8'hff, 8'hff);
      send_request(OP_UNUSED, 8'h00, 8'h00);
      send_request(OP_UNUSED, 8'h5a, 8'ha5);
   endtask

   task automatic test_random_mix();
      repeat (500) send_random_request();
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      repeat (200) send_random_request();
      steady_flow = 1'b0;
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the pipeline fills.
   task automatic test_output_backpressure();
      hold_pending = 1'b1;
      repeat (150) send_random_request();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request waiting", rsp_result, GF_ZERO);
         end else begin
            next_expected = expected_results.pop_front();
            if (rsp_result !== next_expected) begin
               report_mismatch("wrong result", rsp_result, next_expected);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_gf256_arith_unit_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_addition_corners();
      test_multiply_corners();
      test_inverse_corners();
      test_unused_code();
      test_random_mix();
      test_steady_stream();
      test_output_backpressure();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_gf256_arith_unit_top passed");
      end else begin
         $display("tb_gf256_arith_unit_top failed");
      end
      $finish;
   end

endmodule
